FILE: rtl/core/nlms_pkg.sv
// Shared types and constants for the natural merge sort byte unit.
// No dependencies; imported by nlms_ctrl and the top level.
package nlms_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = 6;     // index into the byte, link and run head stores
    localparam int CNT_W   = 7;     // holds 0..MAX_LEN
    localparam int LINK_W  = 7;     // link code: an index, or the end mark
    localparam int CHAR_W  = 8;

    // End of run mark; any link code with its top bit set is an end
    localparam logic [LINK_W-1:0] LINK_END = 7'd127;

    typedef struct packed {
        logic signed [CHAR_W-1:0] char_in;
        logic                     last_in;
    } nlms_in_t;

    typedef struct packed {
        logic signed [CHAR_W-1:0] char_out;
        logic                     last_out;
        logic                     overflow;
    } nlms_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_MRG_CHK,
        ST_MRG_PA,
        ST_MRG_PB,
        ST_MRG_RD,
        ST_MRG_CMP,
        ST_MRG_FIN,
        ST_OUT_HEAD,
        ST_OUT_RD,
        ST_OUT_EMIT
    } nlms_state_t;

endpackage

FILE: rtl/core/nlms_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module nlms_ram #(
    parameter int  Depth = 64,
    parameter int  Width = 8,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr_a,
    input  logic [AddrW-1:0] raddr_b,
    output logic [Width-1:0] rdata_a,
    output logic [Width-1:0] rdata_b
);

    logic [Width-1:0] mem [Depth];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read ports; data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/core/nlms_ctrl.sv
// Sequencer of the sort unit: byte, link and run head stores plus one shared
// signed byte comparator. Depends on nlms_pkg and nlms_ram.
module nlms_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  nlms_pkg::nlms_in_t in_data,
    output logic               in_ready,
    input  logic               out_room,
    output logic               out_push,
    output nlms_pkg::nlms_out_t out_data
);
    import nlms_pkg::*;

    nlms_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              drop_reg, drop_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  qhead_reg, qhead_next;
    logic [CNT_W-1:0]  qcnt_reg, qcnt_next;
    logic [LINK_W-1:0] a_reg, a_next;
    logic [LINK_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              first_reg, first_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // store ports
    logic              byte_we, byte_re;
    logic [IDX_W-1:0]  byte_waddr, byte_raddr_a, byte_raddr_b;
    logic [CHAR_W-1:0] byte_wdata, byte_rd_a, byte_rd_b;
    logic              link_we, link_re;
    logic [IDX_W-1:0]  link_waddr, link_raddr_a, link_raddr_b;
    logic [LINK_W-1:0] link_wdata, link_rd_a, link_rd_b;
    logic              q_we, q_re;
    logic [IDX_W-1:0]  q_waddr, q_raddr, q_wdata, q_rd;

    logic              accept;
    logic              lt;
    logic              i_is_last;
    logic [IDX_W-1:0]  i_inc;
    logic [IDX_W-1:0]  q_tail;
    logic [IDX_W-1:0]  take;
    logic [LINK_W-1:0] nxt, a_after, b_after;
    logic              merge_done;

    nlms_ram #(.Depth(MAX_LEN), .Width(CHAR_W)) u_byte_ram (
        .aclk    (aclk),
        .we      (byte_we),
        .waddr   (byte_waddr),
        .wdata   (byte_wdata),
        .re      (byte_re),
        .raddr_a (byte_raddr_a),
        .raddr_b (byte_raddr_b),
        .rdata_a (byte_rd_a),
        .rdata_b (byte_rd_b)
    );

    nlms_ram #(.Depth(MAX_LEN), .Width(LINK_W)) u_link_ram (
        .aclk    (aclk),
        .we      (link_we),
        .waddr   (link_waddr),
        .wdata   (link_wdata),
        .re      (link_re),
        .raddr_a (link_raddr_a),
        .raddr_b (link_raddr_b),
        .rdata_a (link_rd_a),
        .rdata_b (link_rd_b)
    );

    // run head queue, circular, read through port a only
    nlms_ram #(.Depth(MAX_LEN), .Width(IDX_W)) u_queue_ram (
        .aclk    (aclk),
        .we      (q_we),
        .waddr   (q_waddr),
        .wdata   (q_wdata),
        .re      (q_re),
        .raddr_a (q_raddr),
        .raddr_b ('0),
        .rdata_a (q_rd),
        .rdata_b ()
    );

    // shared comparator and merge step decode
    assign lt         = $signed(byte_rd_a) < $signed(byte_rd_b);
    assign i_inc      = i_reg + IDX_W'(1);
    assign i_is_last  = (CNT_W'(i_reg) + CNT_W'(1)) == cnt_reg;
    assign q_tail     = qhead_reg + qcnt_reg[IDX_W-1:0];
    assign take       = lt ? a_reg[IDX_W-1:0] : b_reg[IDX_W-1:0];
    assign nxt        = lt ? link_rd_a : link_rd_b;
    assign a_after    = lt ? nxt : a_reg;
    assign b_after    = lt ? b_reg : nxt;
    assign merge_done = a_after[LINK_W-1] | b_after[LINK_W-1];

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid & in_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && in_data.last_in) begin
                    state_next = ST_LINK_RD;
                end
            end
            ST_LINK_RD:  state_next = i_is_last ? ST_MRG_CHK : ST_LINK_WR;
            ST_LINK_WR:  state_next = ST_LINK_RD;
            ST_MRG_CHK:  state_next = (qcnt_reg > CNT_W'(1)) ? ST_MRG_PA : ST_OUT_HEAD;
            ST_MRG_PA:   state_next = ST_MRG_PB;
            ST_MRG_PB:   state_next = ST_MRG_RD;
            ST_MRG_RD:   state_next = ST_MRG_CMP;
            ST_MRG_CMP:  state_next = merge_done ? ST_MRG_FIN : ST_MRG_RD;
            ST_MRG_FIN:  state_next = ST_MRG_CHK;
            ST_OUT_HEAD: state_next = ST_OUT_RD;
            ST_OUT_RD:   state_next = ST_OUT_EMIT;
            ST_OUT_EMIT: begin
                if (out_room) begin
                    state_next = i_is_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // datapath, store ports and result request
    always_comb begin
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        qhead_next = qhead_reg;
        qcnt_next  = qcnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        tail_next  = tail_reg;
        head_next  = head_reg;
        first_next = first_reg;
        idx_next   = idx_reg;

        byte_we      = 1'b0;
        byte_waddr   = cnt_reg[IDX_W-1:0];
        byte_wdata   = in_data.char_in;
        byte_re      = 1'b0;
        byte_raddr_a = i_reg;
        byte_raddr_b = i_inc;
        link_we      = 1'b0;
        link_waddr   = i_reg;
        link_wdata   = LINK_END;
        link_re      = 1'b0;
        link_raddr_a = a_reg[IDX_W-1:0];
        link_raddr_b = b_reg[IDX_W-1:0];
        q_we         = 1'b0;
        q_waddr      = q_tail;
        q_wdata      = i_inc;
        q_re         = 1'b0;
        q_raddr      = qhead_reg;

        out_push          = 1'b0;
        out_data.char_out = byte_rd_a;
        out_data.last_out = i_is_last;
        out_data.overflow = drop_reg;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (cnt_reg < CNT_W'(MAX_LEN)) begin
                        byte_we  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    // first run always starts at index zero
                    if (in_data.last_in) begin
                        qhead_next = '0;
                        qcnt_next  = CNT_W'(1);
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = '0;
                        i_next     = '0;
                    end
                end
            end
            ST_LINK_RD: begin
                if (i_is_last) begin
                    link_we = 1'b1;
                end else begin
                    byte_re = 1'b1;
                end
            end
            ST_LINK_WR: begin
                link_we    = 1'b1;
                link_wdata = lt ? LINK_W'(i_inc) : LINK_END;
                if (!lt) begin
                    q_we      = 1'b1;
                    qcnt_next = qcnt_reg + CNT_W'(1);
                end
                i_next = i_inc;
            end
            ST_MRG_CHK: begin
                q_re = 1'b1;
            end
            ST_MRG_PA: begin
                a_next  = LINK_W'(q_rd);
                q_re    = 1'b1;
                q_raddr = qhead_reg + IDX_W'(1);
            end
            ST_MRG_PB: begin
                b_next     = LINK_W'(q_rd);
                qhead_next = qhead_reg + IDX_W'(2);
                qcnt_next  = qcnt_reg - CNT_W'(2);
                first_next = 1'b1;
            end
            ST_MRG_RD: begin
                byte_re      = 1'b1;
                byte_raddr_a = a_reg[IDX_W-1:0];
                byte_raddr_b = b_reg[IDX_W-1:0];
                link_re      = 1'b1;
            end
            ST_MRG_CMP: begin
                // ties go to the second run
                if (first_reg) begin
                    head_next = take;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg;
                    link_wdata = LINK_W'(take);
                end
                tail_next  = take;
                a_next     = a_after;
                b_next     = b_after;
                first_next = 1'b0;
            end
            ST_MRG_FIN: begin
                // hang the rest of the other run on the tail, queue the result
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = a_reg[LINK_W-1] ? b_reg : a_reg;
                q_we       = 1'b1;
                q_wdata    = head_reg;
                qcnt_next  = qcnt_reg + CNT_W'(1);
            end
            ST_OUT_HEAD: begin
                idx_next = q_rd;
                i_next   = '0;
            end
            ST_OUT_RD: begin
                byte_re      = 1'b1;
                byte_raddr_a = idx_reg;
                link_re      = 1'b1;
                link_raddr_a = idx_reg;
            end
            ST_OUT_EMIT: begin
                if (out_room) begin
                    out_push = 1'b1;
                    idx_next = link_rd_a[IDX_W-1:0];
                    i_next   = i_inc;
                    if (i_is_last) begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        qhead_next = '0;
                        qcnt_next  = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            qhead_reg <= '0;
            qcnt_reg  <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            qhead_reg <= qhead_next;
            qcnt_reg  <= qcnt_next;
            first_reg <= first_next;
        end
    end

    // working indexes
    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        tail_reg <= tail_next;
        head_reg <= head_next;
        idx_reg  <= idx_next;
    end

endmodule

FILE: rtl/core/natural_list_merge_sort_bytes_unit.sv
// Top level of the natural merge sort byte unit: input handshake, sequencer
// and result output register. Depends on nlms_pkg and nlms_ctrl.
//
// Usage: bytes of a string arrive on s_data, one request each; last_in marks
// the final byte. Up to 64 bytes are kept; later ones are dropped and every
// result of that string carries overflow. After the final byte s_ready goes
// low while the block links ascending runs, merges run pairs from the run
// head queue, then walks the sorted list. Each result is read from the byte
// and link stores, in ascending signed order, last_out on the final one.
// Loading runs at one byte per cycle. A stalled receiver holds the result in
// the output register and the walk waits on it; s_ready returns the cycle
// after the final result is loaded, so the next string can start while that
// result is still waiting.
// Reset (synchronous, active low) empties the block; stores need no clearing.
module natural_list_merge_sort_bytes_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nlms_pkg::nlms_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nlms_pkg::nlms_out_t m_data
);
    import nlms_pkg::*;

    logic      out_room;
    logic      out_push;
    nlms_out_t out_data;
    logic      m_valid_reg;
    nlms_out_t m_data_reg;

    nlms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_data  (s_data),
        .in_ready (s_ready),
        .out_room (out_room),
        .out_push (out_push),
        .out_data (out_data)
    );

    // result output register
    assign out_room = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // the final byte starts the sort, so no request is taken right after it
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_in) |=> !s_ready)
        else $error("input taken right after final byte");

    // loading and emitting never overlap
    a_no_result_while_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !out_push)
        else $error("result produced while loading");

    // after the final result the block is open for the next string
    a_ready_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_push && out_data.last_out) |=> (s_ready && m_valid))
        else $error("not ready after final result");
`endif

endmodule
